// ----- rtl/ssq_pkg.sv -----
package ssq_pkg;

    localparam int JOY_BITS      = 10;
    localparam int STEP_REG_BITS = 11;
    localparam int COIL_BITS     = 4;
    localparam int PHASE_BITS    = 3;
    localparam int COUNT_BITS_DEF = 11;

    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 4;

    localparam logic [JOY_BITS-1:0]      ABORT_THR_RST  = 10'd300;
    localparam logic [STEP_REG_BITS-1:0] HALF_SWEEP_RST = 11'd568;
    localparam logic [STEP_REG_BITS-1:0] SWEEP_RST      = 11'd1137;

    localparam logic [PHASE_BITS-1:0] PHASE_LAST = 3'd7;

    typedef enum logic [1:0] {
        REG_ABORT_THR  = 2'd0,
        REG_HALF_SWEEP = 2'd1,
        REG_SWEEP      = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        MODE_IDLE      = 3'd0,
        MODE_FIRST     = 3'd1,
        MODE_RIGHT     = 3'd2,
        MODE_LEFT      = 3'd3,
        MODE_HOME_INIT = 3'd4,
        MODE_HOME      = 3'd5
    } t_mode;

    typedef struct packed {
        logic [JOY_BITS-1:0]      abort_threshold;
        logic [STEP_REG_BITS-1:0] half_sweep_steps;
        logic [STEP_REG_BITS-1:0] sweep_steps;
    } t_cfg;

    typedef struct packed {
        logic [COIL_BITS-1:0] coil_pattern;
        logic                 busy_res;
        logic                 homing;
    } t_result;

    // half-step phase pattern, read forward when turning right
    function automatic logic [COIL_BITS-1:0] coil_lookup(input logic [PHASE_BITS-1:0] p);
        logic [COIL_BITS-1:0] c;
        case (p)
            3'd0: c = 4'h1;
            3'd1: c = 4'h3;
            3'd2: c = 4'h2;
            3'd3: c = 4'h6;
            3'd4: c = 4'h4;
            3'd5: c = 4'hC;
            3'd6: c = 4'h8;
            3'd7: c = 4'h9;
            default: c = 4'h0;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/ssq_in_if.sv -----
interface ssq_in_if;
    import ssq_pkg::*;

    logic                valid;
    logic                ready;
    logic [JOY_BITS-1:0] joystick_x;
    logic                enable;

    modport source (output valid, output joystick_x, output enable, input ready);
    modport sink   (input valid, input joystick_x, input enable, output ready);
endinterface

// ----- rtl/ssq_out_if.sv -----
interface ssq_out_if;
    import ssq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [COIL_BITS-1:0] coil_pattern;
    logic                 busy_res;
    logic                 homing;

    modport source (output valid, output coil_pattern, output busy_res, output homing,
                    input ready);
    modport sink   (input valid, input coil_pattern, input busy_res, input homing,
                    output ready);
endinterface

// ----- rtl/ssq_cfg.sv -----
module ssq_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ssq_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [ssq_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [ssq_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready,
    output ssq_pkg::t_cfg                     o_cfg
);
    import ssq_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[APB_ADDR_BITS-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_ABORT_THR:  n_cfg.abort_threshold  = pwdata[JOY_BITS-1:0];
                REG_HALF_SWEEP: n_cfg.half_sweep_steps = pwdata[STEP_REG_BITS-1:0];
                REG_SWEEP:      n_cfg.sweep_steps      = pwdata[STEP_REG_BITS-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_ABORT_THR:  prdata = APB_DATA_BITS'(r_cfg.abort_threshold);
            REG_HALF_SWEEP: prdata = APB_DATA_BITS'(r_cfg.half_sweep_steps);
            REG_SWEEP:      prdata = APB_DATA_BITS'(r_cfg.sweep_steps);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.abort_threshold  <= ABORT_THR_RST;
            r_cfg.half_sweep_steps <= HALF_SWEEP_RST;
            r_cfg.sweep_steps      <= SWEEP_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- rtl/ssq_core.sv -----
module ssq_core #(
    parameter int COUNT_BITS = ssq_pkg::COUNT_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ssq_pkg::t_cfg                i_cfg,
    input  logic                         i_step,
    input  logic [ssq_pkg::JOY_BITS-1:0] i_joystick_x,
    input  logic                         i_enable,
    output ssq_pkg::t_result             o_res
);
    import ssq_pkg::*;

    t_mode                  r_mode,  n_mode,  m_mode;
    logic [COUNT_BITS-1:0]  r_steps, n_steps, m_steps;
    logic [PHASE_BITS-1:0]  r_phase, n_phase, m_phase;
    logic                   r_right, n_right, m_right;
    logic [COIL_BITS-1:0]   r_coil,  n_coil;

    logic                   w_abort;
    logic [COUNT_BITS-1:0]  w_half;
    logic [COUNT_BITS-1:0]  w_sweep;
    logic [COUNT_BITS-1:0]  w_taken;
    logic [COUNT_BITS-1:0]  w_half_less_left;
    logic [COUNT_BITS-1:0]  w_half_less_taken;
    logic [COUNT_BITS-1:0]  w_taken_less_half;
    logic                   w_move;
    logic                   w_dir;

    assign w_abort = (i_joystick_x < i_cfg.abort_threshold) || !i_enable;
    assign w_half  = COUNT_BITS'(i_cfg.half_sweep_steps);
    assign w_sweep = COUNT_BITS'(i_cfg.sweep_steps);

    // saturating differences used when planning the way home
    assign w_taken           = (w_sweep > r_steps) ? (w_sweep - r_steps) : '0;
    assign w_half_less_left  = (w_half > r_steps) ? (w_half - r_steps) : '0;
    assign w_half_less_taken = (w_half > w_taken) ? (w_half - w_taken) : '0;
    assign w_taken_less_half = (w_taken > w_half) ? (w_taken - w_half) : '0;

    // mode transition and run setup
    always_comb begin
        m_mode  = r_mode;
        m_steps = r_steps;
        m_phase = r_phase;
        m_right = r_right;
        case (r_mode)
            MODE_FIRST: begin
                if (w_abort) begin
                    m_steps = w_half_less_left;
                    m_right = 1'b1;
                    m_phase = '0;
                    m_mode  = MODE_HOME_INIT;
                end else if (r_steps == '0) begin
                    m_steps = w_sweep;
                    m_phase = '0;
                    m_right = 1'b1;
                    m_mode  = MODE_RIGHT;
                end
            end
            MODE_LEFT, MODE_RIGHT: begin
                if (w_abort) begin
                    m_mode = MODE_HOME;
                    if (w_taken > r_steps) begin
                        // past the midpoint: reverse and mirror the phase
                        m_right = !r_right;
                        m_steps = w_taken_less_half;
                        m_phase = PHASE_LAST - r_phase;
                    end else if (w_taken < r_steps) begin
                        m_steps = w_half_less_taken;
                    end else begin
                        m_steps = '0;
                    end
                end else if (r_steps == '0) begin
                    m_steps = w_sweep;
                    m_phase = '0;
                    m_right = (r_mode == MODE_LEFT);
                    m_mode  = (r_mode == MODE_LEFT) ? MODE_RIGHT : MODE_LEFT;
                end
            end
            MODE_HOME, MODE_HOME_INIT: begin
                if (r_steps == '0) begin
                    m_mode = MODE_IDLE;
                end
            end
            default: begin
                m_mode = MODE_IDLE;
                if (i_enable) begin
                    m_steps = w_half;
                    m_phase = '0;
                    m_right = 1'b0;
                    m_mode  = MODE_FIRST;
                end
            end
        endcase
    end

    // step action in the new mode
    always_comb begin
        case (m_mode)
            MODE_FIRST, MODE_LEFT: begin
                w_move = 1'b1;
                w_dir  = 1'b0;
            end
            MODE_RIGHT, MODE_HOME_INIT: begin
                w_move = 1'b1;
                w_dir  = 1'b1;
            end
            MODE_HOME: begin
                w_move = 1'b1;
                w_dir  = m_right;
            end
            default: begin
                w_move = 1'b0;
                w_dir  = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_mode  = m_mode;
        n_right = m_right;
        n_steps = m_steps;
        n_phase = m_phase;
        n_coil  = r_coil;
        // zero distance: hold the coils, phase and step count
        if (w_move && (m_steps != '0)) begin
            n_coil  = w_dir ? coil_lookup(m_phase) : coil_lookup(PHASE_LAST - m_phase);
            n_phase = m_phase + PHASE_BITS'(1);
            n_steps = m_steps - COUNT_BITS'(1);
        end
    end

    always_comb begin
        o_res.coil_pattern = n_coil;
        o_res.busy_res     = (n_mode != MODE_IDLE);
        o_res.homing       = (n_mode == MODE_HOME) || (n_mode == MODE_HOME_INIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_steps <= '0;
            r_phase <= '0;
            r_right <= 1'b0;
            r_coil  <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_steps <= n_steps;
            r_phase <= n_phase;
            r_right <= n_right;
            r_coil  <= n_coil;
        end
    end

endmodule

// ----- rtl/ssq_out.sv -----
module ssq_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  ssq_pkg::t_result i_res,
    output logic             o_can_load,
    ssq_out_if.source        o_out
);
    import ssq_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    // take a new result when empty or when the held one leaves this cycle
    assign o_can_load = !r_valid || o_out.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.coil_pattern = r_res.coil_pattern;
    assign o_out.busy_res     = r_res.busy_res;
    assign o_out.homing       = r_res.homing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ----- rtl/stepper_sweep_sequencer.sv -----
// Half-step stepper sweep sequencer. Each accepted request is one tick: the
// block updates its mode, step count and phase and returns one result with the
// four coil bits, a busy flag and a homing flag. A request is taken every clock
// cycle as long as the result register is empty or being drained; its result
// is registered and shows on the output in the cycle after acceptance. The rate
// is set by the single registered state loop (mode, count, phase). Registers sit
// at byte offsets 0 (abort threshold), 4 (half sweep) and 8 (full sweep) of the
// APB port and should be written only while the block is idle.
module stepper_sweep_sequencer #(
    parameter int COUNT_BITS = ssq_pkg::COUNT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ssq_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [ssq_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [ssq_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready,
    ssq_in_if.sink                            i_in,
    ssq_out_if.source                         o_out
);
    import ssq_pkg::*;

    t_cfg    w_cfg;
    t_result w_res;
    logic    w_can_load;
    logic    w_step;

    assign i_in.ready = w_can_load;
    assign w_step     = i_in.valid && w_can_load;

    ssq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ssq_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_step       (w_step),
        .i_joystick_x (i_in.joystick_x),
        .i_enable     (i_in.enable),
        .o_res        (w_res)
    );

    ssq_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_step),
        .i_res      (w_res),
        .o_can_load (w_can_load),
        .o_out      (o_out)
    );

endmodule

// ----- tb/stepper_sweep_sequencer_test.sv -----
`timescale 1ns / 1ps

module stepper_sweep_sequencer_test;
    import ssq_pkg::*;

    localparam int CW         = COUNT_BITS_DEF;
    localparam int IDLE_LIMIT = 4000;

    typedef struct {
        logic [JOY_BITS-1:0] joy;
        logic                en;
    } t_joy_sample;

    localparam logic [COIL_BITS-1:0] HALF_STEP_COILS [0:7] =
        '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic pready;

    ssq_in_if  in_ch ();
    ssq_out_if out_ch ();

    stepper_sweep_sequencer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // stimulus and expected results
    t_joy_sample sample_q[$];
    t_result     coil_expect_q[$];

    // sequencer state as predicted
    t_mode                    seq_mode;
    logic [CW-1:0]            seq_left;
    logic [PHASE_BITS-1:0]    seq_phase;
    logic                     seq_right;
    logic [COIL_BITS-1:0]     seq_coil;
    logic [JOY_BITS-1:0]      cfg_thr;
    logic [STEP_REG_BITS-1:0] cfg_half;
    logic [STEP_REG_BITS-1:0] cfg_sweep;

    int  issued_n;
    int  accepted_n;
    int  checked_n;
    int  fail_n;
    int  first_aborts_n;
    int  sweep_aborts_n;
    int  zero_moves_n;
    int  idle_cycles;
    int  gap_left;
    int  stall_left;
    bit  in_idle_on;
    bit  out_idle_on;
    logic req_taken;

    always #2 i_clk = ~i_clk;

    function automatic logic [CW-1:0] floor_sub(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    task automatic predict_tick(input t_joy_sample s);
        logic                  stop_req;
        logic                  fwd;
        logic [CW-1:0]         taken;
        logic [PHASE_BITS-1:0] tap;
        t_result               r;
        stop_req = (s.joy < cfg_thr) || !s.en;
        case (seq_mode)
            MODE_FIRST: begin
                if (stop_req) begin
                    seq_left  = floor_sub(cfg_half, seq_left);
                    seq_right = 1'b1;
                    seq_phase = '0;
                    seq_mode  = MODE_HOME_INIT;
                    first_aborts_n++;
                end else if (seq_left == '0) begin
                    seq_left  = cfg_sweep;
                    seq_phase = '0;
                    seq_right = 1'b1;
                    seq_mode  = MODE_RIGHT;
                end
            end
            MODE_RIGHT, MODE_LEFT: begin
                if (stop_req) begin
                    // head home the short way, flipping once past the midpoint
                    taken = floor_sub(cfg_sweep, seq_left);
                    if (taken > seq_left) begin
                        seq_right = !seq_right;
                        seq_left  = floor_sub(taken, cfg_half);
                        seq_phase = PHASE_LAST - seq_phase;
                    end else if (taken < seq_left) begin
                        seq_left = floor_sub(cfg_half, taken);
                    end else begin
                        seq_left = '0;
                    end
                    seq_mode = MODE_HOME;
                    sweep_aborts_n++;
                end else if (seq_left == '0) begin
                    seq_left  = cfg_sweep;
                    seq_phase = '0;
                    seq_right = (seq_mode == MODE_LEFT);
                    seq_mode  = (seq_mode == MODE_LEFT) ? MODE_RIGHT : MODE_LEFT;
                end
            end
            MODE_HOME, MODE_HOME_INIT: begin
                if (seq_left == '0)
                    seq_mode = MODE_IDLE;
            end
            default: begin
                seq_mode = MODE_IDLE;
                if (s.en) begin
                    seq_left  = cfg_half;
                    seq_phase = '0;
                    seq_right = 1'b0;
                    seq_mode  = MODE_FIRST;
                end
            end
        endcase

        fwd = (seq_mode == MODE_RIGHT) || (seq_mode == MODE_HOME_INIT) ||
              (seq_mode == MODE_HOME && seq_right);
        if (seq_mode != MODE_IDLE) begin
            if (seq_left == '0) begin
                zero_moves_n++;
            end else begin
                tap       = fwd ? seq_phase : PHASE_LAST - seq_phase;
                seq_coil  = HALF_STEP_COILS[tap];
                seq_phase = seq_phase + PHASE_BITS'(1);
                seq_left  = seq_left - CW'(1);
            end
        end

        r.coil_pattern = seq_coil;
        r.busy_res     = (seq_mode != MODE_IDLE);
        r.homing       = (seq_mode == MODE_HOME) || (seq_mode == MODE_HOME_INIT);
        coil_expect_q.push_back(r);
    endtask

    // predict on accepted requests, check accepted results, watch for a hang
    always @(posedge i_clk) begin
        t_joy_sample s;
        t_result     want;
        if (!i_rst_n) begin
            req_taken   <= 1'b0;
            idle_cycles <= 0;
        end else begin
            req_taken <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready) begin
                s.joy = in_ch.joystick_x;
                s.en  = in_ch.enable;
                predict_tick(s);
                accepted_n++;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (coil_expect_q.size() == 0) begin
                    $error("result with nothing expected: coil_pattern %h", out_ch.coil_pattern);
                    fail_n++;
                end else begin
                    want = coil_expect_q.pop_front();
                    checked_n++;
                    if (out_ch.coil_pattern !== want.coil_pattern) begin
                        $error("coil_pattern: expected %h, got %h",
                               want.coil_pattern, out_ch.coil_pattern);
                        fail_n++;
                    end
                    if (out_ch.busy_res !== want.busy_res) begin
                        $error("busy_res: expected %b, got %b", want.busy_res, out_ch.busy_res);
                        fail_n++;
                    end
                    if (out_ch.homing !== want.homing) begin
                        $error("homing: expected %b, got %b", want.homing, out_ch.homing);
                        fail_n++;
                    end
                end
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // request driver
    always @(negedge i_clk) begin
        t_joy_sample nxt;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!(in_ch.valid && !req_taken)) begin
            if (gap_left > 0) begin
                gap_left    <= gap_left - 1;
                in_ch.valid <= 1'b0;
            end else if (sample_q.size() > 0) begin
                nxt = sample_q.pop_front();
                in_ch.joystick_x <= nxt.joy;
                in_ch.enable     <= nxt.en;
                in_ch.valid      <= 1'b1;
                issued_n++;
                gap_left <= in_idle_on ? idle_len() : 0;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
            if (out_idle_on && $urandom_range(0, 3) == 0)
                stall_left <= idle_len();
        end
    end

    task automatic queue_sample(input logic [JOY_BITS-1:0] joy, input logic en);
        t_joy_sample s;
        s.joy = joy;
        s.en  = en;
        sample_q.push_back(s);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (sample_q.size() != 0 || accepted_n != issued_n || coil_expect_q.size() != 0)
            @(negedge i_clk);
    endtask

    // stop the motor and let it walk back to centre before touching registers
    task automatic park_at_centre();
        wait_drained();
        while (seq_mode != MODE_IDLE) begin
            repeat (16) queue_sample(JOY_BITS'($urandom_range(0, 1023)), 1'b0);
            wait_drained();
        end
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [APB_DATA_BITS-1:0] val);
        logic [APB_DATA_BITS-1:0] rd;
        logic [APB_DATA_BITS-1:0] mask;
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_ABORT_THR: begin
                cfg_thr = val[JOY_BITS-1:0];
                mask    = (1 << JOY_BITS) - 1;
            end
            REG_HALF_SWEEP: begin
                cfg_half = val[STEP_REG_BITS-1:0];
                mask     = (1 << STEP_REG_BITS) - 1;
            end
            default: begin
                cfg_sweep = val[STEP_REG_BITS-1:0];
                mask      = (1 << STEP_REG_BITS) - 1;
            end
        endcase
        // read back
        psel = 1'b1;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if ((rd & mask) !== (val & mask)) begin
            $error("register %s read back: expected %h, got %h", idx.name(), val & mask, rd & mask);
            fail_n++;
        end
    endtask

    task automatic set_config(input int thr, input int half, input int sweep);
        write_reg(REG_ABORT_THR, thr);
        write_reg(REG_HALF_SWEEP, half);
        write_reg(REG_SWEEP, sweep);
    endtask

    task automatic run_phase(input int thr, input int half, input int sweep, input int n,
                             input bit idle_in, input bit idle_out);
        int done;
        int len;
        int cap;
        int k;
        park_at_centre();
        set_config(thr, half, sweep);
        in_idle_on  = idle_in;
        out_idle_on = idle_out;
        cap  = half + 2 * sweep + 3;
        cap  = (cap > 40) ? 40 : cap;
        done = 0;
        while (done < n) begin
            if ($urandom_range(0, 9) < 2) begin
                // noise
                queue_sample(JOY_BITS'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
                done++;
            end else begin
                // a run: play for a while, then abort and let it go home
                len = $urandom_range(1, cap);
                for (k = 0; k < len; k++)
                    queue_sample(JOY_BITS'($urandom_range(thr, 1023)), 1'b1);
                if (thr > 0 && $urandom_range(0, 1) == 1)
                    queue_sample(JOY_BITS'($urandom_range(0, thr - 1)), 1'b1);
                else
                    queue_sample(JOY_BITS'($urandom_range(0, 1023)), 1'b0);
                done += len + 1;
                len = $urandom_range(0, 6);
                for (k = 0; k < len; k++)
                    queue_sample(JOY_BITS'($urandom_range(0, 1023)), 1'b0);
                done += len;
                // hold the sender until every result is back
                if ($urandom_range(0, 9) == 0)
                    wait_drained();
            end
        end
        park_at_centre();
    endtask

    initial begin
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_ch.valid      = 1'b0;
        in_ch.joystick_x = '0;
        in_ch.enable     = 1'b0;
        out_ch.ready     = 1'b0;
        gap_left         = 0;
        stall_left       = 0;
        in_idle_on       = 1'b0;
        out_idle_on      = 1'b0;
        issued_n         = 0;
        accepted_n       = 0;
        checked_n        = 0;
        fail_n           = 0;
        first_aborts_n   = 0;
        sweep_aborts_n   = 0;
        zero_moves_n     = 0;
        seq_mode         = MODE_IDLE;
        seq_left         = '0;
        seq_phase        = '0;
        seq_right        = 1'b0;
        seq_coil         = '0;
        cfg_thr          = ABORT_THR_RST;
        cfg_half         = HALF_SWEEP_RST;
        cfg_sweep        = SWEEP_RST;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: threshold edge, abort in the first swing, stop by enable
        queue_sample(10'd0, 1'b0);
        queue_sample(10'd1023, 1'b1);
        queue_sample(10'd299, 1'b1);
        queue_sample(10'd1023, 1'b1);
        queue_sample(10'd300, 1'b1);
        queue_sample(10'd300, 1'b1);
        queue_sample(10'd0, 1'b0);
        park_at_centre();

        // short sweeps: abort at the midpoint, before it and past it
        set_config(512, 2, 4);
        queue_sample(10'd1023, 1'b1);
        queue_sample(10'd600, 1'b1);
        queue_sample(10'd700, 1'b1);
        queue_sample(10'd800, 1'b1);
        queue_sample(10'd511, 1'b1);
        queue_sample(10'd0, 1'b0);
        repeat (7) queue_sample(10'd1023, 1'b1);
        queue_sample(10'd0, 1'b1);
        queue_sample(10'd0, 1'b0);
        repeat (5) queue_sample(10'd1023, 1'b1);
        queue_sample(10'd0, 1'b0);

        run_phase(512, 3, 7, 120, 1'b1, 1'b1);
        run_phase(0, 1, 1, 80, 1'b0, 1'b0);
        run_phase(1023, 5, 10, 80, 1'b1, 1'b0);
        run_phase(200, 2047, 2047, 60, 1'b0, 1'b1);
        run_phase(100, 4, 8, 120, 1'b1, 1'b1);
        run_phase(700, 2, 3, 100, 1'b1, 1'b1);
        run_phase(300, 9, 2, 90, 1'b0, 1'b0);

        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("covered %0d requests and %0d results over 9 register settings",
                 accepted_n, checked_n);
        $display("aborts in first swing %0d, in sweeps %0d; ticks with zero distance %0d",
                 first_aborts_n, sweep_aborts_n, zero_moves_n);
        if (fail_n == 0 && coil_expect_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
